// ===== src/twld_pkg.sv =====
// Package for the two-wire LED display refresher.
// Holds item structs, sequencer enums, register indexes and fixed constants.
// Depends on nothing; used by two_wire_led_display_refresher.sv.
package twld_pkg;

    localparam int DIGITS = 6;
    localparam int DIGIT_IDX_W = 3;
    localparam int BYTE_CNT_W = DIGIT_IDX_W + 1;
    localparam logic [BYTE_CNT_W-1:0] DIGITS_CNT = BYTE_CNT_W'(DIGITS);

    localparam logic [7:0] HALF_BIT_TICKS = 8'd10;
    localparam logic [7:0] CONTROL_BYTE = 8'hF1;
    localparam logic [3:0] ACK_BIT = 4'd8;

    localparam logic [7:0] DATA_COMMAND_RST = 8'h40;
    localparam logic [7:0] FIRST_ADDRESS_RST = 8'hC0;
    localparam logic [7:0] DISPLAY_SETTING_RST = 8'h0F;
    localparam logic [7:0] SHADOW_FIRST_RST = 8'hFF;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_COMMAND = 2'd0;
    localparam logic [1:0] CFG_FIRST_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_DISPLAY_SETTING = 2'd2;

    typedef enum logic [1:0] {
        FR_CTRL,
        FR_CTRL_GATED,
        FR_CMD,
        FR_ADDR
    } frame_t;

    typedef enum logic [2:0] {
        ST_S1,
        ST_S2,
        ST_B1,
        ST_B2,
        ST_P1,
        ST_P2
    } step_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] digit_index;
        logic [7:0] digit_value;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic scl;
        logic sda_out;
        logic busy_res;
        logic link_ok;
    } out_item_t;

endpackage

// ===== src/two_wire_led_display_refresher.sv =====
// Two-wire LED display refresher: bit-serial master for an LED driver chip.
// Uses twld_pkg for item structs, sequencer enums and constants.
//
// Usage:
// - Input channel (in_valid/in_ready/in_item): each item is a tick that
//   steps the wire sequence, a load of one staged digit byte, or an update
//   request. Every input item yields exactly one result item.
// - Output channel (out_valid/out_ready/out_item): the wire levels to drive
//   (scl, sda_out), busy_res and link_ok, all as they stand after the item.
// - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes
//   data_command, first_address or display_setting; always ready. Write
//   only while no item is in flight. Indexes past the list are ignored.
// The result is registered on acceptance. One item is accepted every cycle
// unless stalled; the whole update is a single pass of logic into the state
// and result registers. Each wire step lasts HALF_BIT_TICKS tick items.
// A single result register parts the sides: while a result waits for
// out_ready, in_ready stays low. Reset returns the sequencer to idle, the
// link to down, the registers and digit stores to their reset values.
module two_wire_led_display_refresher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  twld_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output twld_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    logic [7:0] data_command_reg;
    logic [7:0] first_address_reg;
    logic [7:0] display_setting_reg;

    logic [7:0] staged_reg [twld_pkg::DIGITS];
    logic [7:0] staged_next [twld_pkg::DIGITS];
    logic [7:0] shadow_reg [twld_pkg::DIGITS];
    logic [7:0] shadow_next [twld_pkg::DIGITS];
    logic [7:0] sent_setting_reg, sent_setting_next;
    logic       link_reg, link_next;
    logic       busy_reg, busy_next;
    twld_pkg::frame_t frame_reg, frame_next;
    twld_pkg::step_t  step_reg, step_next;
    logic [3:0] bit_idx_reg, bit_idx_next;
    logic [twld_pkg::DIGIT_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic       cont_reg, cont_next;
    logic [7:0] delay_reg, delay_next;
    logic [7:0] shift_reg, shift_next;

    logic                out_valid_reg, out_valid_next;
    twld_pkg::out_item_t out_item_reg, out_item_next;

    logic accept;
    logic [7:0] delay_inc;
    logic [twld_pkg::BYTE_CNT_W-1:0] byte_inc;
    logic changed;
    logic resend;
    logic level;

    assign accept = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

    assign delay_inc = delay_reg + 8'd1;
    assign byte_inc = {1'b0, byte_idx_reg} + twld_pkg::BYTE_CNT_W'(1);

    // Next state of the sequencer and the digit stores for the current item.
    always_comb
    begin
        staged_next = staged_reg;
        shadow_next = shadow_reg;
        sent_setting_next = sent_setting_reg;
        link_next = link_reg;
        busy_next = busy_reg;
        frame_next = frame_reg;
        step_next = step_reg;
        bit_idx_next = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        cont_next = cont_reg;
        delay_next = delay_reg;
        shift_next = shift_reg;
        changed = 1'b0;
        resend = 1'b0;

        if (in_item.req_type == twld_pkg::REQ_TICK)
        begin
            if (!busy_reg)
            begin
                delay_next = 8'd0;
                bit_idx_next = 4'd0;
                byte_idx_next = '0;
                cont_next = 1'b0;
            end
            else if (delay_inc < twld_pkg::HALF_BIT_TICKS)
            begin
                delay_next = delay_inc;
            end
            else
            begin
                delay_next = 8'd0;
                unique case (step_reg)
                    twld_pkg::ST_S1: step_next = twld_pkg::ST_S2;
                    twld_pkg::ST_S2: step_next = twld_pkg::ST_B1;
                    twld_pkg::ST_B1:
                    begin
                        // The acknowledge of a control frame decides the link state.
                        if (bit_idx_reg >= twld_pkg::ACK_BIT &&
                            (frame_reg == twld_pkg::FR_CTRL ||
                             frame_reg == twld_pkg::FR_CTRL_GATED))
                        begin
                            link_next = !in_item.sda_in;
                        end
                        step_next = twld_pkg::ST_B2;
                    end
                    twld_pkg::ST_B2:
                    begin
                        if (bit_idx_reg < twld_pkg::ACK_BIT)
                        begin
                            bit_idx_next = bit_idx_reg + 4'd1;
                            shift_next = {shift_reg[6:0], 1'b0};
                            step_next = twld_pkg::ST_B1;
                        end
                        else if (frame_reg == twld_pkg::FR_ADDR &&
                                 byte_inc <= twld_pkg::DIGITS_CNT)
                        begin
                            shift_next = shadow_reg[byte_idx_reg];
                            bit_idx_next = 4'd0;
                            byte_idx_next = byte_inc[twld_pkg::DIGIT_IDX_W-1:0];
                            step_next = twld_pkg::ST_B1;
                        end
                        else
                        begin
                            step_next = twld_pkg::ST_P1;
                        end
                    end
                    twld_pkg::ST_P1: step_next = twld_pkg::ST_P2;
                    default:
                    begin
                        bit_idx_next = 4'd0;
                        byte_idx_next = '0;
                        step_next = twld_pkg::ST_S1;
                        if (frame_reg == twld_pkg::FR_CMD)
                        begin
                            frame_next = twld_pkg::FR_ADDR;
                            shift_next = first_address_reg;
                        end
                        else if ((frame_reg == twld_pkg::FR_CTRL && cont_reg) ||
                                 (frame_reg == twld_pkg::FR_CTRL_GATED && link_reg))
                        begin
                            frame_next = twld_pkg::FR_CMD;
                            shift_next = data_command_reg;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                            cont_next = 1'b0;
                        end
                    end
                endcase
            end
        end
        else if (in_item.req_type == twld_pkg::REQ_LOAD)
        begin
            if ({1'b0, in_item.digit_index} < twld_pkg::DIGITS_CNT)
            begin
                staged_next[in_item.digit_index] = in_item.digit_value;
            end
        end
        else if (in_item.req_type == twld_pkg::REQ_UPDATE && !busy_reg)
        begin
            if (link_reg)
            begin
                resend = (display_setting_reg != sent_setting_reg);
                for (int i = 0; i < twld_pkg::DIGITS; i++)
                begin
                    if (shadow_reg[i] != staged_reg[i])
                    begin
                        shadow_next[i] = staged_reg[i];
                        changed = 1'b1;
                    end
                end
                if (resend)
                begin
                    sent_setting_next = display_setting_reg;
                    frame_next = twld_pkg::FR_CTRL;
                    shift_next = twld_pkg::CONTROL_BYTE;
                    cont_next = changed;
                end
                else
                begin
                    frame_next = twld_pkg::FR_CMD;
                    shift_next = data_command_reg;
                    cont_next = 1'b0;
                end
                if (resend || changed)
                begin
                    busy_next = 1'b1;
                    step_next = twld_pkg::ST_S1;
                    delay_next = 8'd0;
                    bit_idx_next = 4'd0;
                    byte_idx_next = '0;
                end
            end
            else
            begin
                busy_next = 1'b1;
                frame_next = twld_pkg::FR_CTRL_GATED;
                step_next = twld_pkg::ST_S1;
                shift_next = twld_pkg::CONTROL_BYTE;
                delay_next = 8'd0;
                bit_idx_next = 4'd0;
                byte_idx_next = '0;
                cont_next = 1'b0;
            end
        end
    end

    // Wire levels for the state that follows the current item.
    always_comb
    begin
        level = (bit_idx_next >= twld_pkg::ACK_BIT) ? 1'b1 : shift_next[7];
        out_item_next.busy_res = busy_next;
        out_item_next.link_ok = link_next;
        out_item_next.scl = 1'b1;
        out_item_next.sda_out = 1'b1;
        if (busy_next)
        begin
            unique case (step_next)
                twld_pkg::ST_S1:
                begin
                    out_item_next.scl = 1'b1;
                    out_item_next.sda_out = 1'b1;
                end
                twld_pkg::ST_S2:
                begin
                    out_item_next.scl = 1'b1;
                    out_item_next.sda_out = 1'b0;
                end
                twld_pkg::ST_B1:
                begin
                    out_item_next.scl = 1'b1;
                    out_item_next.sda_out = level;
                end
                twld_pkg::ST_B2:
                begin
                    out_item_next.scl = 1'b0;
                    out_item_next.sda_out = level;
                end
                twld_pkg::ST_P1:
                begin
                    out_item_next.scl = 1'b0;
                    out_item_next.sda_out = 1'b0;
                end
                default:
                begin
                    out_item_next.scl = 1'b1;
                    out_item_next.sda_out = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_command_reg <= twld_pkg::DATA_COMMAND_RST;
            first_address_reg <= twld_pkg::FIRST_ADDRESS_RST;
            display_setting_reg <= twld_pkg::DISPLAY_SETTING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                twld_pkg::CFG_DATA_COMMAND: data_command_reg <= cfg_data;
                twld_pkg::CFG_FIRST_ADDRESS: first_address_reg <= cfg_data;
                twld_pkg::CFG_DISPLAY_SETTING: display_setting_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < twld_pkg::DIGITS; i++)
            begin
                staged_reg[i] <= 8'd0;
                shadow_reg[i] <= (i == 0) ? twld_pkg::SHADOW_FIRST_RST : 8'd0;
            end
            sent_setting_reg <= twld_pkg::DISPLAY_SETTING_RST;
            link_reg <= 1'b0;
            busy_reg <= 1'b0;
            frame_reg <= twld_pkg::FR_CTRL;
            step_reg <= twld_pkg::ST_S1;
            bit_idx_reg <= 4'd0;
            byte_idx_reg <= '0;
            cont_reg <= 1'b0;
            delay_reg <= 8'd0;
            shift_reg <= 8'd0;
        end
        else if (accept)
        begin
            staged_reg <= staged_next;
            shadow_reg <= shadow_next;
            sent_setting_reg <= sent_setting_next;
            link_reg <= link_next;
            busy_reg <= busy_next;
            frame_reg <= frame_next;
            step_reg <= step_next;
            bit_idx_reg <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            cont_reg <= cont_next;
            delay_reg <= delay_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef SYNTHESIS
    // While idle the bit, byte and continue fields are all clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (bit_idx_reg == 4'd0 && byte_idx_reg == '0 && !cont_reg))
        else $error("counters not clear while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        delay_reg < twld_pkg::HALF_BIT_TICKS)
        else $error("half-bit delay counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= twld_pkg::ACK_BIT)
        else $error("bit index past the acknowledge bit");

    // Only the address frame walks through digit bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, byte_idx_reg} <= twld_pkg::DIGITS_CNT &&
        (byte_idx_reg == '0 || frame_reg == twld_pkg::FR_ADDR))
        else $error("byte index outside the address frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");
`endif

endmodule
